@@ hdl/gregorian_solar_hijri_converter_top_macros.svh @@
// Assertion macros used by the calendar converter datapath.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef GREGORIAN_SOLAR_HIJRI_CONVERTER_TOP_MACROS_SVH
`define GREGORIAN_SOLAR_HIJRI_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define GSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define GSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gsh_pkg.sv @@
// Shared types, constants and calendar tables for the date converter.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package gsh_pkg;

    localparam int YEAR_SPAN_DEF = 51;
    localparam int TBL_DEPTH     = 51;
    localparam int TBL_IW        = 6;
    localparam int DAY_W         = 22;

    localparam logic ACT_G2S = 1'b0;
    localparam logic ACT_S2G = 1'b1;

    localparam logic [11:0]      GREG_FIRST  = 12'd2000;
    localparam logic [11:0]      SOLAR_FIRST = 12'd1380;
    localparam logic [11:0]      YEAR_GAP_LO = 12'd621;
    localparam logic [11:0]      YEAR_GAP_HI = 12'd622;
    localparam logic [8:0]       YEAR_DAYS   = 9'd365;
    localparam logic [9:0]       SOLAR_BASE  = 10'd343;
    localparam logic [9:0]       GREG_BASE   = 10'd499;
    localparam logic [DAY_W-1:0] DAY_OFFSET  = 22'd226899;

    localparam logic [11:0] SOLAR_LEAPS [0:14] = '{
        12'd1375, 12'd1379, 12'd1383, 12'd1387, 12'd1391, 12'd1395, 12'd1399, 12'd1404,
        12'd1408, 12'd1412, 12'd1416, 12'd1420, 12'd1424, 12'd1428, 12'd1432};
    localparam logic [11:0] GREG_LEAPS [0:13] = '{
        12'd2000, 12'd2004, 12'd2008, 12'd2012, 12'd2016, 12'd2020, 12'd2024, 12'd2028,
        12'd2032, 12'd2036, 12'd2040, 12'd2044, 12'd2048, 12'd2052};

    localparam logic [4:0] MARCH_CUT [0:TBL_DEPTH-1] = '{
        5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21, 5'd21,
        5'd21, 5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21,
        5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20,
        5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21,
        5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21};
    localparam logic [4:0] DEY_CUT [0:TBL_DEPTH-1] = '{
        5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11, 5'd11,
        5'd12, 5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11,
        5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12,
        5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12,
        5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_CALC3,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic calc1;
        logic calc2;
        logic calc3;
        logic walk;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [3:0] solar_leap_cnt(input logic [11:0] y);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 15; i++) begin
            c = c + 4'(SOLAR_LEAPS[i] < y);
        end
        return c;
    endfunction

    function automatic logic [3:0] greg_leap_cnt(input logic [11:0] y);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 14; i++) begin
            c = c + 4'(GREG_LEAPS[i] < y);
        end
        return c;
    endfunction

    function automatic logic is_solar_leap(input logic [11:0] y);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 15; i++) begin
            hit = hit | (SOLAR_LEAPS[i] == y);
        end
        return hit;
    endfunction

    function automatic logic is_greg_leap(input logic [11:0] y);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 14; i++) begin
            hit = hit | (GREG_LEAPS[i] == y);
        end
        return hit;
    endfunction

    // Days in the months before m, common year.
    function automatic logic [8:0] greg_cum(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [8:0] solar_cum(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd62;
            4'd4:    c = 9'd93;
            4'd5:    c = 9'd124;
            4'd6:    c = 9'd155;
            4'd7:    c = 9'd186;
            4'd8:    c = 9'd216;
            4'd9:    c = 9'd246;
            4'd10:   c = 9'd276;
            4'd11:   c = 9'd306;
            4'd12:   c = 9'd336;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Month length; zero for a month outside 1..12.
    function automatic logic [4:0] month_len(input logic solar, input logic leap,
                                             input logic [3:0] m);
        logic [4:0] len;
        if (solar) begin
            case (m)
                4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: len = 5'd31;
                4'd7, 4'd8, 4'd9, 4'd10, 4'd11:     len = 5'd30;
                4'd12:                              len = leap ? 5'd30 : 5'd29;
                default:                            len = 5'd0;
            endcase
        end else begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
        end
        return len;
    endfunction

    // Final reduction of an octal digit sum modulo 7.
    function automatic logic [2:0] mod7_fold(input logic [5:0] s);
        logic [3:0] a;
        logic [3:0] b;
        a = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        b = (a >= 4'd7) ? a - 4'd7 : a;
        return (b == 4'd7) ? 3'd0 : b[2:0];
    endfunction

endpackage

@@ hdl/gsh_ctrl.sv @@
// Sequencer for the date converter: steps the datapath through check,
// day count, month walk and result hand-off. Depends on gsh_pkg.
`timescale 1ns / 1ps

module gsh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  gsh_pkg::t_dp_sts i_sts,
    output gsh_pkg::t_dp_cmd o_cmd
);

    gsh_pkg::t_state r_state;
    gsh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gsh_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = gsh_pkg::ST_CALC1;
                end
            end
            gsh_pkg::ST_CALC1: begin
                n_state = gsh_pkg::ST_CALC2;
            end
            gsh_pkg::ST_CALC2: begin
                // skip the count and walk for a rejected date
                n_state = i_sts.err ? gsh_pkg::ST_FINISH : gsh_pkg::ST_CALC3;
            end
            gsh_pkg::ST_CALC3: begin
                n_state = gsh_pkg::ST_WALK;
            end
            gsh_pkg::ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = gsh_pkg::ST_FINISH;
                end
            end
            gsh_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = gsh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gsh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            gsh_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            gsh_pkg::ST_CALC1: begin
                o_cmd.calc1 = 1'b1;
            end
            gsh_pkg::ST_CALC2: begin
                o_cmd.calc2 = 1'b1;
            end
            gsh_pkg::ST_CALC3: begin
                o_cmd.calc3 = 1'b1;
            end
            gsh_pkg::ST_WALK: begin
                o_cmd.walk = 1'b1;
            end
            gsh_pkg::ST_FINISH: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/gsh_datapath.sv @@
// Datapath of the date converter: input check, day counts, target year,
// month walk, weekday and the output register. Depends on gsh_pkg and the macro header.
`timescale 1ns / 1ps
`include "gregorian_solar_hijri_converter_top_macros.svh"

module gsh_datapath #(
    parameter int YEAR_SPAN = gsh_pkg::YEAR_SPAN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gsh_pkg::t_dp_cmd i_cmd,
    output gsh_pkg::t_dp_sts o_sts,
    input  logic [23:0]      i_s_tdata,
    input  logic [0:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,
    output logic [0:0]       o_m_tuser
);

    localparam int IW = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
    localparam int DW = gsh_pkg::DAY_W;

    // source item
    logic        r_action;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    // intermediate results
    logic                 r_err;
    logic [20:0]          r_prod;
    logic [9:0]           r_part;
    logic [11:0]          r_ty;
    logic                 r_tleap;
    logic [DW-1:0]        r_gdays;
    logic [DW-1:0]        r_tbase;
    logic signed [DW-1:0] r_n;
    logic [3:0]           r_mi;
    logic [3:0]           r_tm;
    logic [5:0]           r_msum;

    // output register
    logic        r_out_valid;
    logic        r_out_status;
    logic [11:0] r_out_year;
    logic [3:0]  r_out_month;
    logic [4:0]  r_out_day;
    logic [2:0]  r_out_wday;

    // check and source count
    logic [11:0]          w_base;
    logic [12:0]          w_off;
    logic                 w_in_range;
    logic [IW-1:0]        w_idx;
    logic [gsh_pkg::TBL_IW-1:0] w_tidx;
    logic                 w_src_leap;
    logic [3:0]           w_src_cnt;
    logic                 w_mon_ok;
    logic                 w_day_ok;
    logic [8:0]           w_cum;
    logic [9:0]           w_part;
    logic [11:0]          w_year_m1;
    logic [20:0]          w_prod;
    logic [11:0]          w_ty;
    // target count
    logic [DW-1:0]        w_src_days;
    logic [DW-1:0]        w_gdays;
    logic [11:0]          w_ty_m1;
    logic [DW-1:0]        w_tprod;
    logic [DW-1:0]        w_tbase;
    logic                 w_tgt_solar;
    // weekday digit sum and walk
    logic [5:0]           w_msum;
    logic [23:0]          w_gpad;
    logic [4:0]           w_len;
    logic signed [DW-1:0] w_len_s;
    logic                 w_fail;
    logic                 w_found;

    assign w_tgt_solar = (r_action == gsh_pkg::ACT_G2S);

    always_comb begin
        w_base     = (r_action == gsh_pkg::ACT_S2G) ? gsh_pkg::SOLAR_FIRST : gsh_pkg::GREG_FIRST;
        w_off      = {1'b0, r_year} - {1'b0, w_base};
        w_in_range = !w_off[12] && (w_off < 13'(YEAR_SPAN));
        w_idx      = w_off[IW-1:0];
        w_tidx     = w_in_range ? gsh_pkg::TBL_IW'(w_idx) : '0;

        if (r_action == gsh_pkg::ACT_S2G) begin
            w_src_leap = gsh_pkg::is_solar_leap(r_year);
            w_src_cnt  = gsh_pkg::solar_leap_cnt(r_year);
            w_cum      = gsh_pkg::solar_cum(r_month);
        end else begin
            w_src_leap = gsh_pkg::is_greg_leap(r_year);
            w_src_cnt  = gsh_pkg::greg_leap_cnt(r_year);
            w_cum      = gsh_pkg::greg_cum(r_month)
                       + 9'(w_src_leap && (r_month > 4'd2));
        end

        w_mon_ok = r_month inside {[4'd1:4'd12]};
        w_day_ok = (r_day != 5'd0)
                && (r_day <= gsh_pkg::month_len(r_action, w_src_leap, r_month));

        w_part = 10'(r_day) + 10'(w_cum) + 10'(w_src_cnt)
               + ((r_action == gsh_pkg::ACT_S2G) ? gsh_pkg::SOLAR_BASE : gsh_pkg::GREG_BASE);

        w_year_m1 = r_year - 12'd1;
        w_prod    = {9'd0, w_year_m1} * {12'd0, gsh_pkg::YEAR_DAYS};

        // target year from the cutover day of the month holding New Year
        if (r_action == gsh_pkg::ACT_G2S) begin
            if (r_month < 4'd3) begin
                w_ty = r_year - gsh_pkg::YEAR_GAP_HI;
            end else if (r_month > 4'd3) begin
                w_ty = r_year - gsh_pkg::YEAR_GAP_LO;
            end else begin
                w_ty = (r_day >= gsh_pkg::MARCH_CUT[w_tidx])
                     ? r_year - gsh_pkg::YEAR_GAP_LO : r_year - gsh_pkg::YEAR_GAP_HI;
            end
        end else begin
            if (r_month < 4'd10) begin
                w_ty = r_year + gsh_pkg::YEAR_GAP_LO;
            end else if (r_month > 4'd10) begin
                w_ty = r_year + gsh_pkg::YEAR_GAP_HI;
            end else begin
                w_ty = (r_day >= gsh_pkg::DEY_CUT[w_tidx])
                     ? r_year + gsh_pkg::YEAR_GAP_HI : r_year + gsh_pkg::YEAR_GAP_LO;
            end
        end
    end

    always_comb begin
        w_src_days = DW'(r_prod) + DW'(r_part);
        w_gdays    = (r_action == gsh_pkg::ACT_S2G) ? w_src_days + gsh_pkg::DAY_OFFSET
                                                    : w_src_days;
        w_ty_m1    = r_ty - 12'd1;
        w_tprod    = {10'd0, w_ty_m1} * {13'd0, gsh_pkg::YEAR_DAYS};
        if (w_tgt_solar) begin
            w_tbase = w_tprod + DW'(gsh_pkg::SOLAR_BASE)
                    + DW'(gsh_pkg::solar_leap_cnt(r_ty)) + gsh_pkg::DAY_OFFSET;
        end else begin
            w_tbase = w_tprod + DW'(gsh_pkg::GREG_BASE) + DW'(gsh_pkg::greg_leap_cnt(r_ty));
        end
    end

    // 8 is congruent to 1 modulo 7, so octal digits sum to the same residue
    always_comb begin
        w_gpad = 24'(r_gdays);
        w_msum = '0;
        for (int k = 0; k < 8; k++) begin
            w_msum = w_msum + 6'(w_gpad[3*k +: 3]);
        end
    end

    always_comb begin
        w_len   = gsh_pkg::month_len(w_tgt_solar, r_tleap, r_mi);
        w_len_s = signed'(DW'(w_len));
        w_fail  = (r_n < signed'(DW'(1))) || ((r_n > w_len_s) && (r_mi == 4'd12));
        w_found = !(r_n < signed'(DW'(1))) && (r_n <= w_len_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_s_tuser[0];
            r_year   <= i_s_tdata[11:0];
            r_month  <= i_s_tdata[15:12];
            r_day    <= i_s_tdata[20:16];
        end
        if (i_cmd.calc1) begin
            r_prod <= w_prod;
            r_part <= w_part;
            r_ty   <= w_ty;
        end
        if (i_cmd.calc2) begin
            r_gdays <= w_gdays;
            r_tbase <= w_tbase;
            r_tleap <= w_tgt_solar ? gsh_pkg::is_solar_leap(r_ty) : gsh_pkg::is_greg_leap(r_ty);
        end
        if (i_cmd.calc3) begin
            r_n    <= signed'(r_gdays - r_tbase);
            r_mi   <= 4'd1;
            r_msum <= w_msum;
        end
        if (i_cmd.walk && !w_fail) begin
            if (w_found) begin
                r_tm <= r_mi;
            end else begin
                // advance to the next month
                r_n  <= r_n - w_len_s;
                r_mi <= r_mi + 4'd1;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_err;
            r_out_year   <= r_err ? 12'd0 : r_ty;
            r_out_month  <= r_err ? 4'd0 : r_tm;
            r_out_day    <= r_err ? 5'd0 : r_n[4:0];
            r_out_wday   <= r_err ? 3'd0 : gsh_pkg::mod7_fold(r_msum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.calc1) begin
                r_err <= !(w_in_range && w_mon_ok && w_day_ok);
            end else if (i_cmd.walk && w_fail) begin
                r_err <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.err       = r_err;
    assign o_sts.walk_done = i_cmd.walk && (w_fail || w_found);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_wday, r_out_day, r_out_month, r_out_year};
    assign o_m_tuser  = r_out_status;

    `GSH_ASSERT_NOW(a_err_fields_zero, r_out_valid && r_out_status,
        r_out_year == 12'd0 && r_out_month == 4'd0 && r_out_day == 5'd0 && r_out_wday == 3'd0,
        "error beat carries nonzero date fields")
    `GSH_ASSERT_NOW(a_ok_fields_legal, r_out_valid && !r_out_status,
        r_out_month >= 4'd1 && r_out_month <= 4'd12 && r_out_day != 5'd0 && r_out_wday <= 3'd6,
        "valid beat carries an illegal date")
    `GSH_ASSERT_NOW(a_walk_month_legal, i_cmd.walk,
        r_mi >= 4'd1 && r_mi <= 4'd12, "month walk ran past December")
    `GSH_ASSERT_NOW(a_emit_slot_free, i_cmd.emit,
        !r_out_valid || i_m_tready, "result written over an untaken beat")
    `GSH_ASSERT_NEXT(a_emit_shows, i_cmd.emit, r_out_valid, "written result not presented")

endmodule

@@ hdl/gregorian_solar_hijri_converter_top.sv @@
// Gregorian / Solar Hijri date converter: one result beat per input beat.
// A date passes through the check, the day count and the month walk and is then
// registered as the result beat; a rejected date skips the count and the walk.
// The walk tries one month per cycle. A new input beat is taken only after the last
// result is written, which waits while an untaken result beat holds the output. Synchronous active-low
// reset clears the sequencer and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module gregorian_solar_hijri_converter_top #(
    parameter int YEAR_SPAN = gsh_pkg::YEAR_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_year[11:0], in_month[15:12], in_day[20:16], zero pad
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_year[11:0], out_month[15:12], out_day[20:16],
                                   // weekday[23:21]
    output logic [0:0]  m_tuser    // status[0]
);

    gsh_pkg::t_dp_cmd w_cmd;
    gsh_pkg::t_dp_sts w_sts;

    gsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gsh_datapath #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule
